// ===== rtl/core/due_time_request_scheduler_defines.svh =====
// assertion macros for the due time request scheduler
// no dependencies; bodies expect clock and reset in scope
`ifndef DUE_TIME_REQUEST_SCHEDULER_DEFINES_SVH
`define DUE_TIME_REQUEST_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DTRS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define DTRS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define DTRS_ASSERT(label, prop)
`define DTRS_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== rtl/core/dtrs_pkg.sv =====
// types and constants for the due time request scheduler
// no dependencies
`timescale 1ns / 1ps
package dtrs_pkg;

   localparam int SLOTS     = 8;
   localparam int ID_BITS   = 16;
   localparam int TIME_BITS = 48;
   localparam int SEQ_BITS  = 32;
   localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_TAKE    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_APPLY,
      ST_STATUS
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [ID_BITS-1:0]     tone_id;
      logic [TIME_BITS-1:0]   due_time;
      logic [TIME_BITS-1:0]   now_time;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [ID_BITS-1:0]     sound_out;
      logic                   evicted;
      logic [TIME_BITS-1:0]   late_by;
      logic                   any_active;
      logic                   any_due;
   } rsp_type;

endpackage

// ===== rtl/core/due_time_request_scheduler.sv =====
// due time request scheduler: table of timed requests with a slot-serial scan
// depends on dtrs_pkg and due_time_request_scheduler_defines.svh
//
// usage:
//   a transaction is taken when start is high and busy is low; req_data carries
//   op, tone_id, due_time and now_time. busy stays high until the result.
//   each transaction gives one result on rsp_data, marked by rsp_valid for one
//   cycle; the receiver cannot stall it and must take it in that cycle.
// sequencing:
//   one compare unit walks the table one slot a cycle. enqueue and take run a
//   pick pass (enqueue stops at the first free slot), an update step, and a
//   due status pass over every slot. clear, OP_NONE and zero-id enqueues skip
//   the pick pass. busy drops in the cycle that rsp_valid is high, so the next
//   transaction can be taken then.
// reset:
//   synchronous reset empties the table, zeroes the sequence counter and
//   returns to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`include "due_time_request_scheduler_defines.svh"
module due_time_request_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dtrs_pkg::req_type req_data,
   output logic              rsp_valid,
   output dtrs_pkg::rsp_type rsp_data
);
   import dtrs_pkg::*;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [IDX_BITS-1:0]    sel_idx_ff, sel_idx_in;
   logic [TIME_BITS-1:0]   sel_due_ff, sel_due_in;
   logic [SEQ_BITS-1:0]    sel_seq_ff, sel_seq_in;
   logic                   sel_found_ff, sel_found_in;
   logic                   due_acc_ff, due_acc_in;
   logic [SEQ_BITS-1:0]    seq_ff, seq_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;

   logic [TIME_BITS-1:0]   entry_due_ff   [SLOTS];
   logic [SEQ_BITS-1:0]    entry_seq_ff   [SLOTS];
   logic [ID_BITS-1:0]     entry_sound_ff [SLOTS];

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_idx;
   logic [SEQ_BITS-1:0]    seq_next;

   // shared compare unit on the slot under the scan pointer
   logic [TIME_BITS-1:0]   cur_due;
   logic [SEQ_BITS-1:0]    cur_seq;
   logic                   cur_valid;
   logic                   le_now, due_lt, due_eq, seq_lt, seq_gt;

   assign cur_due   = entry_due_ff[idx_ff];
   assign cur_seq   = entry_seq_ff[idx_ff];
   assign cur_valid = valid_ff[idx_ff];
   assign le_now    = cur_due <= req_ff.now_time;
   assign due_lt    = cur_due < sel_due_ff;
   assign due_eq    = cur_due == sel_due_ff;
   assign seq_lt    = cur_seq < sel_seq_ff;
   assign seq_gt    = cur_seq > sel_seq_ff;

   assign seq_next  = (seq_ff == '1) ? SEQ_BITS'(1) : seq_ff + SEQ_BITS'(1);

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         seq_ff       <= '0;
         sel_found_ff <= 1'b0;
         due_acc_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         seq_ff       <= seq_in;
         sel_found_ff <= sel_found_in;
         due_acc_ff   <= due_acc_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      sel_idx_ff <= sel_idx_in;
      sel_due_ff <= sel_due_in;
      sel_seq_ff <= sel_seq_in;
      if (wr_en) begin
         entry_due_ff[wr_idx]   <= req_ff.due_time;
         entry_seq_ff[wr_idx]   <= seq_next;
         entry_sound_ff[wr_idx] <= req_ff.tone_id;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      idx_in       = idx_ff;
      sel_idx_in   = sel_idx_ff;
      sel_due_in   = sel_due_ff;
      sel_seq_in   = sel_seq_ff;
      sel_found_in = sel_found_ff;
      due_acc_in   = due_acc_ff;
      seq_in       = seq_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;
      wr_idx       = sel_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               rsp_in       = '0;
               idx_in       = '0;
               sel_found_in = 1'b0;
               due_acc_in   = 1'b0;
               if (req_data.op == OP_TAKE ||
                   (req_data.op == OP_ENQUEUE && req_data.tone_id != '0)) begin
                  state_in = ST_PICK;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_PICK: begin
            idx_in = idx_ff + IDX_BITS'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_APPLY;
            end
            if (req_ff.op == OP_ENQUEUE) begin
               if (!cur_valid) begin
                  sel_idx_in   = idx_ff;
                  sel_found_in = 1'b1;
                  state_in     = ST_APPLY;
               end else if (!sel_found_ff || (!due_lt && !due_eq) || (due_eq && seq_gt)) begin
                  sel_idx_in   = idx_ff;
                  sel_due_in   = cur_due;
                  sel_seq_in   = cur_seq;
                  sel_found_in = 1'b1;
               end
            end else if (cur_valid && le_now &&
                         (!sel_found_ff || due_lt || (due_eq && seq_lt))) begin
               sel_idx_in   = idx_ff;
               sel_due_in   = cur_due;
               sel_seq_in   = cur_seq;
               sel_found_in = 1'b1;
            end
         end
         ST_APPLY: begin
            idx_in   = '0;
            state_in = ST_STATUS;
            case (req_ff.op)
               OP_ENQUEUE: begin
                  if (req_ff.tone_id != '0) begin
                     if (valid_ff[sel_idx_ff]) begin
                        rsp_in.sound_out = entry_sound_ff[sel_idx_ff];
                        rsp_in.evicted   = 1'b1;
                     end
                     rsp_in.ok            = 1'b1;
                     wr_en                = 1'b1;
                     seq_in               = seq_next;
                     valid_in[sel_idx_ff] = 1'b1;
                  end
               end
               OP_TAKE: begin
                  if (sel_found_ff) begin
                     rsp_in.ok            = 1'b1;
                     rsp_in.sound_out     = entry_sound_ff[sel_idx_ff];
                     rsp_in.late_by       = req_ff.now_time - sel_due_ff;
                     valid_in[sel_idx_ff] = 1'b0;
                  end
               end
               OP_CLEAR: begin
                  valid_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_STATUS: begin
            if (idx_ff == LAST_IDX) begin
               rsp_in.any_due    = due_acc_ff | (cur_valid & le_now);
               rsp_in.any_active = |valid_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               idx_in     = idx_ff + IDX_BITS'(1);
               due_acc_in = due_acc_ff | (cur_valid & le_now);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `DTRS_ASSERT_IMPL(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE)
   `DTRS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
   `DTRS_ASSERT_IMPL(a_evict_ok, rsp_valid_ff && rsp_ff.evicted, rsp_ff.ok)
   `DTRS_ASSERT_IMPL(a_due_active, rsp_valid_ff && rsp_ff.any_due, rsp_ff.any_active)
   `DTRS_ASSERT(a_seq_nonzero, valid_ff == '0 || seq_ff != '0)

endmodule
